// ----- hw/rtl/ttrlp_pkg.sv -----
// Package: shared constants, codes and types for the typed transaction RLP checker
`default_nettype none
package ttrlp_pkg;
    localparam int LENGTH_BITS = 32;

    localparam logic [3:0] PH_TYPE      = 4'd0;
    localparam logic [3:0] PH_OUTER     = 4'd1;
    localparam logic [3:0] PH_OUTER_LEN = 4'd2;
    localparam logic [3:0] PH_ISTART    = 4'd3;
    localparam logic [3:0] PH_ILEN      = 4'd4;
    localparam logic [3:0] PH_IPAY      = 4'd5;
    localparam logic [3:0] PH_TRAIL     = 4'd6;
    localparam logic [3:0] PH_ERR       = 4'd7;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_TYPE      = 4'd1;
    localparam logic [3:0] ERR_OUTER     = 4'd2;
    localparam logic [3:0] ERR_NONCANON  = 4'd3;
    localparam logic [3:0] ERR_LENGTH    = 4'd4;
    localparam logic [3:0] ERR_LEADZERO  = 4'd5;
    localparam logic [3:0] ERR_KIND      = 4'd6;
    localparam logic [3:0] ERR_DESC      = 4'd7;
    localparam logic [3:0] ERR_EXTRA     = 4'd8;
    localparam logic [3:0] ERR_MISMATCH  = 4'd9;
    localparam logic [3:0] ERR_TRUNC     = 4'd10;
    localparam logic [3:0] ERR_OVERFLOW  = 4'd11;

    localparam logic [1:0] REG_MAX_VALUE = 2'd0;
    localparam logic [1:0] REG_MAX_NONCE = 2'd1;
    localparam logic [1:0] REG_MAX_GAS   = 2'd2;
    localparam logic [1:0] REG_ADDRESS   = 2'd3;

    localparam logic [3:0] ITEM_CHAIN = 4'd1;
    localparam logic [3:0] ITEM_NONCE = 4'd2;
    localparam logic [3:0] ITEM_TIP   = 4'd3;
    localparam logic [3:0] ITEM_FEE   = 4'd4;
    localparam logic [3:0] ITEM_GAS   = 4'd5;
    localparam logic [3:0] ITEM_TO    = 4'd6;
    localparam logic [3:0] ITEM_VALUE = 4'd7;
    localparam logic [3:0] ITEM_DATA  = 4'd8;
    localparam logic [3:0] ITEM_ACL   = 4'd9;
    localparam logic [3:0] ITEM_DESC  = 4'd10;
    localparam logic [3:0] ITEM_EXTRA = 4'd11;

    typedef logic [LENGTH_BITS-1:0] len_t;

    typedef struct packed {
        logic [7:0] max_value_bytes;
        logic [7:0] max_nonce_bytes;
        logic [7:0] max_gas_bytes;
        logic [7:0] address_bytes;
    } cfg_t;

    typedef struct packed {
        logic [3:0] field;
        logic [7:0] value_byte;
        logic       value_valid;
        logic       done_res;
        logic       accepted;
        logic [3:0] error_code;
    } result_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ttrlp_cfg.sv -----
// Configuration register bank for the typed transaction RLP checker
`default_nettype none
module ttrlp_cfg
    import ttrlp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output cfg_t            cfg
);
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_value_bytes <= 8'd32;
            cfg_reg.max_nonce_bytes <= 8'd8;
            cfg_reg.max_gas_bytes   <= 8'd8;
            cfg_reg.address_bytes   <= 8'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_VALUE: cfg_reg.max_value_bytes <= cfg_data;
                REG_MAX_NONCE: cfg_reg.max_nonce_bytes <= cfg_data;
                REG_MAX_GAS:   cfg_reg.max_gas_bytes   <= cfg_data;
                REG_ADDRESS:   cfg_reg.address_bytes   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/ttrlp_core.sv -----
// Parser state and per-byte check logic for the typed transaction RLP checker
`default_nettype none
module ttrlp_core
    import ttrlp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  cfg_t            cfg,
    input  wire logic       step,
    input  wire logic [7:0] b,
    input  wire logic       lst,
    output result_t         res,
    output logic [3:0]      phase
);
    logic [3:0] phase_reg, phase_next;
    logic [3:0] item_reg, item_next;
    logic [7:0] prefix_reg, prefix_next;
    logic [3:0] lenleft_reg, lenleft_next;
    len_t       ibl_reg, ibl_next;
    len_t       lbl_reg, lbl_next;
    logic       fvp_reg, fvp_next;
    logic [3:0] ferr_reg, ferr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE;
            item_reg    <= '0;
            prefix_reg  <= '0;
            lenleft_reg <= '0;
            ibl_reg     <= '0;
            lbl_reg     <= '0;
            fvp_reg     <= 1'b0;
            ferr_reg    <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            item_reg    <= item_next;
            prefix_reg  <= prefix_next;
            lenleft_reg <= lenleft_next;
            ibl_reg     <= ibl_next;
            lbl_reg     <= lbl_next;
            fvp_reg     <= fvp_next;
            ferr_reg    <= ferr_next;
        end
    end

    assign phase = phase_reg;

    function automatic logic [3:0] hdr_code(input logic [3:0] item, input len_t len,
                                            input cfg_t c);
        logic [3:0] code;
        code = ERR_NONE;
        unique case (item)
            ITEM_CHAIN, ITEM_TIP, ITEM_FEE, ITEM_VALUE:
                if (len > len_t'(c.max_value_bytes)) code = ERR_LENGTH;
            ITEM_NONCE: if (len > len_t'(c.max_nonce_bytes)) code = ERR_LENGTH;
            ITEM_GAS:   if (len > len_t'(c.max_gas_bytes)) code = ERR_LENGTH;
            ITEM_TO:
                if (len != '0 && len != len_t'(c.address_bytes)) code = ERR_LENGTH;
            ITEM_DESC:  if (len != len_t'(3)) code = ERR_DESC;
            ITEM_EXTRA: if (len != '0) code = ERR_EXTRA;
            default: ;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] val_code(input logic [3:0] item, input logic [7:0] bt,
                                            input logic first, input len_t left);
        logic [3:0] code;
        logic       intg;
        code = ERR_NONE;
        intg = (item >= ITEM_CHAIN && item <= ITEM_GAS) || item == ITEM_VALUE;
        if (intg && first && bt == 8'h00)
            code = ERR_LEADZERO;
        else if (item == ITEM_DESC)
        begin
            if (left >= len_t'(3) ? (bt != 8'h01) : (bt != 8'h00))
                code = ERR_DESC;
        end
        return code;
    endfunction

    always_comb
    begin
        logic [3:0] err;
        logic       vv;
        logic       in_item;
        logic       complete;
        logic       begin_pay;
        len_t       pay_len;
        len_t       acc;
        logic [3:0] code;

        phase_next   = phase_reg;
        item_next    = item_reg;
        prefix_next  = prefix_reg;
        lenleft_next = lenleft_reg;
        ibl_next     = ibl_reg;
        lbl_next     = lbl_reg;
        fvp_next     = fvp_reg;
        ferr_next    = ferr_reg;
        err       = ERR_NONE;
        vv        = 1'b0;
        complete  = 1'b0;
        begin_pay = 1'b0;
        pay_len   = '0;
        acc       = '0;
        code      = ERR_NONE;

        in_item = phase_reg == PH_ISTART || phase_reg == PH_ILEN || phase_reg == PH_IPAY;
        if (in_item)
        begin
            if (lbl_reg == '0) err = ERR_MISMATCH;
            else lbl_next = lbl_reg - len_t'(1);
        end

        unique case (phase_reg)
            PH_TYPE:
                if (b != 8'h02) err = ERR_TYPE;
                else phase_next = PH_OUTER;
            PH_OUTER:
                if (b < 8'hc0) err = ERR_OUTER;
                else if (b <= 8'hf7)
                begin
                    lbl_next   = len_t'(b - 8'hc0);
                    item_next  = ITEM_CHAIN;
                    phase_next = PH_ISTART;
                end
                else
                begin
                    lenleft_next = 4'(b - 8'hf7);
                    lbl_next     = '0;
                    phase_next   = PH_OUTER_LEN;
                end
            PH_OUTER_LEN:
            begin
                if (lbl_reg == '0 && b == 8'h00) err = ERR_NONCANON;
                else if (lbl_reg[LENGTH_BITS-1 -: 8] != 8'h00) err = ERR_OVERFLOW;
                else
                begin
                    acc          = {lbl_reg[LENGTH_BITS-9:0], b};
                    lbl_next     = acc;
                    lenleft_next = lenleft_reg - 4'd1;
                    if (lenleft_reg == 4'd1)
                    begin
                        if (acc < len_t'(56)) err = ERR_NONCANON;
                        else
                        begin
                            item_next  = ITEM_CHAIN;
                            phase_next = PH_ISTART;
                        end
                    end
                end
            end
            PH_ISTART:
            begin
                prefix_next = b;
                if ((item_reg == ITEM_DATA && b >= 8'hc0) ||
                    (item_reg == ITEM_ACL && b < 8'hc0))
                    err = ERR_KIND;
                else if (b <= 8'h7f)
                begin
                    code = hdr_code(item_reg, len_t'(1), cfg);
                    if (code == ERR_NONE) code = val_code(item_reg, b, 1'b1, len_t'(3));
                    if (code != ERR_NONE) err = code;
                    else
                    begin
                        vv       = 1'b1;
                        complete = 1'b1;
                    end
                end
                else if (b <= 8'hb7)
                begin
                    begin_pay = 1'b1;
                    pay_len   = len_t'(b - 8'h80);
                end
                else if (b <= 8'hbf)
                begin
                    lenleft_next = 4'(b - 8'hb7);
                    ibl_next     = '0;
                    phase_next   = PH_ILEN;
                end
                else if (b <= 8'hf7)
                begin
                    begin_pay = 1'b1;
                    pay_len   = len_t'(b - 8'hc0);
                end
                else
                begin
                    lenleft_next = 4'(b - 8'hf7);
                    ibl_next     = '0;
                    phase_next   = PH_ILEN;
                end
            end
            PH_ILEN:
            begin
                if (ibl_reg == '0 && b == 8'h00) err = ERR_NONCANON;
                else if (ibl_reg[LENGTH_BITS-1 -: 8] != 8'h00) err = ERR_OVERFLOW;
                else
                begin
                    acc          = {ibl_reg[LENGTH_BITS-9:0], b};
                    ibl_next     = acc;
                    lenleft_next = lenleft_reg - 4'd1;
                    if (lenleft_reg == 4'd1)
                    begin
                        if (acc < len_t'(56)) err = ERR_NONCANON;
                        else
                        begin
                            begin_pay = 1'b1;
                            pay_len   = acc;
                        end
                    end
                end
            end
            PH_IPAY:
            begin
                if (fvp_reg && prefix_reg == 8'h81 && b < 8'h80) err = ERR_NONCANON;
                else
                begin
                    code = val_code(item_reg, b, fvp_reg, ibl_reg);
                    if (code != ERR_NONE) err = code;
                    else
                    begin
                        vv       = 1'b1;
                        fvp_next = 1'b0;
                        ibl_next = ibl_reg - len_t'(1);
                        if (ibl_reg == len_t'(1)) complete = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (begin_pay && err == ERR_NONE)
        begin
            code = hdr_code(item_reg, pay_len, cfg);
            if (code != ERR_NONE) err = code;
            else
            begin
                ibl_next = pay_len;
                if (pay_len == '0) complete = 1'b1;
                else
                begin
                    phase_next = PH_IPAY;
                    fvp_next   = 1'b1;
                end
            end
        end

        if (complete && err == ERR_NONE)
        begin
            if (item_reg >= ITEM_EXTRA)
            begin
                if (lbl_next != '0) err = ERR_MISMATCH;
                else phase_next = PH_TRAIL;
            end
            else
            begin
                item_next  = item_reg + 4'd1;
                phase_next = PH_ISTART;
            end
        end

        if (in_item && lbl_reg == '0) err = ERR_MISMATCH;

        if (err != ERR_NONE)
        begin
            phase_next = PH_ERR;
            if (ferr_reg == ERR_NONE) ferr_next = err;
        end
        if (phase_next == PH_ERR) vv = 1'b0;

        res.field       = in_item ? item_reg : 4'd0;
        res.value_byte  = b;
        res.value_valid = vv;
        res.done_res    = lst;
        res.accepted    = 1'b0;
        res.error_code  = ERR_NONE;
        if (lst)
        begin
            res.error_code = ferr_next;
            if (ferr_next == ERR_NONE && phase_next != PH_TRAIL) res.error_code = ERR_TRUNC;
            res.accepted = res.error_code == ERR_NONE;
            phase_next   = PH_TYPE;
            item_next    = '0;
            prefix_next  = '0;
            lenleft_next = '0;
            ibl_next     = '0;
            lbl_next     = '0;
            fvp_next     = 1'b0;
            ferr_next    = ERR_NONE;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ttrlp_outreg.sv -----
// Output register with skid stage for the checker result
`default_nettype none
module ttrlp_outreg
    import ttrlp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  result_t   in_res,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_res
);
    logic    main_valid_reg, skid_valid_reg;
    result_t main_reg, skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || out_ready)
            begin
                main_valid_reg <= skid_valid_reg || (in_valid && in_ready);
                skid_valid_reg <= 1'b0;
            end
            else if (in_valid && in_ready)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
            main_reg <= skid_valid_reg ? skid_reg : in_res;
        if (in_valid && in_ready)
            skid_reg <= in_res;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/typed_tx_rlp_checker_top.sv -----
// Top level of the typed transaction RLP checker
// channel | direction | transfer when         | payload
// in      | input     | in_valid & in_ready   | tx_byte, last
// out     | output    | out_valid & out_ready | field, value_byte, value_valid, done_res,
//         |           |                       | accepted, error_code
// cfg     | input     | cfg_we                | cfg_index, cfg_data
// One byte per cycle while in_ready is high; each result is registered in the output stage.
// Each accepted byte updates the parser state registers.
// rst_n clears parser state and sets registers to their reset values.
// A stalled output fills a one-entry skid stage, then in_ready drops.
`default_nettype none
module typed_tx_rlp_checker_top
    import ttrlp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] tx_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      field,
    output logic [7:0]      value_byte,
    output logic            value_valid,
    output logic            done_res,
    output logic            accepted,
    output logic [3:0]      error_code,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    cfg_t       cfg;
    result_t    res, ores;
    logic       step;
    logic [3:0] phase;

    assign step = in_valid && in_ready;

    ttrlp_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    ttrlp_core u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .step(step), .b(tx_byte),
        .lst(last), .res(res), .phase(phase)
    );

    ttrlp_outreg u_out (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_res(res), .out_valid(out_valid), .out_ready(out_ready), .out_res(ores)
    );

    assign field       = ores.field;
    assign value_byte  = ores.value_byte;
    assign value_valid = ores.value_valid;
    assign done_res    = ores.done_res;
    assign accepted    = ores.accepted;
    assign error_code  = ores.error_code;

`ifndef SYNTHESIS
    a_done_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> phase == PH_TYPE)
        else $error("parser not reset after last byte");
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (done_res && error_code == ERR_NONE))
        else $error("accepted with error or without done");
    a_code_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (error_code == ERR_NONE && !accepted))
        else $error("verdict on a non-final byte");
`endif
endmodule
`default_nettype wire
